>>> design/teb_pkg.sv
`default_nettype none
package teb_pkg;

   localparam int ESCAPE_DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS          = 32;
   localparam int RUN_CNT_W            = 6;
   localparam int QUEUE_DEPTH          = 2;
   localparam int MAX_STR_W            = 21;
   localparam logic [MAX_STR_W-1:0] MAX_STR_RESET = 21'd65536;

   localparam logic [2:0] KIND_PRINT    = 3'd0;
   localparam logic [2:0] KIND_CONTROL  = 3'd1;
   localparam logic [2:0] KIND_SIMPLE   = 3'd2;
   localparam logic [2:0] KIND_DESIGN   = 3'd3;
   localparam logic [2:0] KIND_CSI      = 3'd4;
   localparam logic [2:0] KIND_STR_BYTE = 3'd5;
   localparam logic [2:0] KIND_STR_END  = 3'd6;

   // one queued job: a single result, or a run of stored CSI bytes
   typedef struct packed {
      logic                 is_run;
      logic [2:0]           kind;
      logic [30:0]          value;
      logic [7:0]           aux;
      logic                 priv;
      logic                 hold;
      logic [RUN_CNT_W-1:0] run_cnt;
   } cmd_type;

endpackage
`default_nettype wire

>>> design/teb_queue.sv
`default_nettype none
module teb_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  teb_pkg::cmd_type      push_cmd,
   input  wire logic             pop,
   output teb_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);
   import teb_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      fill_ff, fill_in;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> design/teb_front.sv
`default_nettype none
module teb_front #(
   parameter int ESCAPE_DEPTH = teb_pkg::ESCAPE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic [7:0]                        req_data_byte,
   output logic                                   req_stall,
   input  wire logic [teb_pkg::MAX_STR_W-1:0]     max_string_bytes,
   output logic                                   push,
   output teb_pkg::cmd_type                       push_cmd,
   input  wire logic                              q_full,
   input  wire logic                              run_done,
   output logic                                   esc_we,
   output logic [$clog2(ESCAPE_DEPTH)-1:0]        esc_waddr,
   output logic [7:0]                             esc_wdata
);
   import teb_pkg::*;

   localparam int AW = $clog2(ESCAPE_DEPTH);
   localparam int EW = $clog2(ESCAPE_DEPTH + 1);

   localparam logic [7:0] C_ESC  = 8'h1b;
   localparam logic [7:0] C_BEL  = 8'h07;
   localparam logic [7:0] C_QM   = 8'h3f;
   localparam logic [13:0] SYNC_MODE = 14'd2026;
   localparam logic [13:0] SYNC_SAT  = 14'd16383;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_UTF8,
      MODE_ESCAPE,
      MODE_STRING
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [2:0]          u_cnt_ff, u_cnt_in;
   logic [2:0]          u_exp_ff, u_exp_in;
   logic [30:0]         acc_ff, acc_in;
   logic [EW-1:0]       esc_cnt_ff, esc_cnt_in;
   logic [7:0]          lead_ff, lead_in;
   logic [7:0]          second_ff, second_in;
   logic [7:0]          str_type_ff, str_type_in;
   logic [MAX_STR_W-1:0] str_cnt_ff, str_cnt_in;
   logic                str_pend_ff, str_pend_in;
   logic                hold_ff, hold_in;
   logic [13:0]         sp_ff, sp_in;
   logic                sf_digits_ff, sf_digits_in;
   logic                sf_found_ff, sf_found_in;
   logic                sf_bad_ff, sf_bad_in;
   logic                busy_ff, busy_in;

   logic                accept;
   logic [7:0]          b;
   logic                do_normal;
   logic                emit;
   logic [2:0]          u_next;
   logic [30:0]         acc_next;
   logic [EW-1:0]       cnt_new;
   logic [7:0]          lead;
   logic [7:0]          sec;
   logic [17:0]         sp_wide;
   logic                hit;

   assign b         = req_data_byte;
   assign req_stall = q_full | busy_ff;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & emit;

   always_comb begin
      mode_in      = mode_ff;
      u_cnt_in     = u_cnt_ff;
      u_exp_in     = u_exp_ff;
      acc_in       = acc_ff;
      esc_cnt_in   = esc_cnt_ff;
      lead_in      = lead_ff;
      second_in    = second_ff;
      str_type_in  = str_type_ff;
      str_cnt_in   = str_cnt_ff;
      str_pend_in  = str_pend_ff;
      hold_in      = hold_ff;
      sp_in        = sp_ff;
      sf_digits_in = sf_digits_ff;
      sf_found_in  = sf_found_ff;
      sf_bad_in    = sf_bad_ff;
      busy_in      = busy_ff;
      do_normal    = 1'b0;
      emit         = 1'b0;
      esc_we       = 1'b0;
      esc_waddr    = esc_cnt_ff[AW-1:0];
      esc_wdata    = b;
      push_cmd     = '0;
      u_next       = u_cnt_ff + 3'd1;
      acc_next     = {acc_ff[24:0], b[5:0]};
      cnt_new      = esc_cnt_ff + EW'(1);
      lead         = (esc_cnt_ff == '0) ? b : lead_ff;
      sec          = (esc_cnt_ff == EW'(1)) ? b : second_ff;
      sp_wide      = 18'(sp_ff) * 18'd10 + 18'(b[3:0]);
      hit          = 1'b0;

      if (run_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         case (mode_ff)
            MODE_NORMAL: begin
               do_normal = 1'b1;
            end
            MODE_UTF8: begin
               if (b[7:6] != 2'b10) begin
                  u_cnt_in  = '0;
                  u_exp_in  = '0;
                  acc_in    = '0;
                  mode_in   = MODE_NORMAL;
                  do_normal = 1'b1;
               end else if (u_next == u_exp_ff) begin
                  emit           = 1'b1;
                  push_cmd.kind  = KIND_PRINT;
                  push_cmd.value = acc_next;
                  u_cnt_in       = '0;
                  u_exp_in       = '0;
                  acc_in         = '0;
                  mode_in        = MODE_NORMAL;
               end else if (u_next >= 3'd6 || u_next > u_exp_ff) begin
                  u_cnt_in = '0;
                  u_exp_in = '0;
                  acc_in   = '0;
                  mode_in  = MODE_NORMAL;
               end else begin
                  u_cnt_in = u_next;
                  acc_in   = acc_next;
               end
            end
            MODE_ESCAPE: begin
               if (b == C_ESC) begin
                  esc_cnt_in = '0;
               end else if (32'(esc_cnt_ff) >= 32'(ESCAPE_DEPTH)) begin
                  mode_in    = MODE_NORMAL;
                  esc_cnt_in = '0;
               end else begin
                  esc_we     = 1'b1;
                  esc_cnt_in = cnt_new;
                  if (esc_cnt_ff == '0) begin
                     lead_in      = b;
                     sp_in        = '0;
                     sf_digits_in = 1'b0;
                     sf_found_in  = 1'b0;
                     sf_bad_in    = 1'b0;
                  end
                  if (esc_cnt_ff == EW'(1)) begin
                     second_in = b;
                  end
                  case (lead)
                     8'h4e, 8'h4f, 8'h5c: begin
                        if (str_pend_ff) begin
                           emit         = 1'b1;
                           push_cmd.kind = KIND_STR_END;
                           push_cmd.aux  = str_type_ff;
                           str_pend_in  = 1'b0;
                        end
                        mode_in    = MODE_NORMAL;
                        esc_cnt_in = '0;
                     end
                     8'h50, 8'h5d, 8'h58, 8'h5e, 8'h5f: begin
                        str_type_in = lead;
                        str_cnt_in  = '0;
                        str_pend_in = 1'b0;
                        mode_in     = MODE_STRING;
                        esc_cnt_in  = '0;
                     end
                     8'h5b: begin
                        if (cnt_new > EW'(1)) begin
                           if (b >= 8'h40 && b <= 8'h7e) begin
                              hit = (32'(cnt_new) >= 32'd3) &&
                                    (b == 8'h68 || b == 8'h6c) &&
                                    (sf_found_ff ||
                                     (!sf_bad_ff && sf_digits_ff && sp_ff == SYNC_MODE));
                              if (hit) begin
                                 hold_in = (b == 8'h68);
                              end
                              emit            = 1'b1;
                              push_cmd.is_run = 1'b1;
                              push_cmd.kind   = KIND_CSI;
                              push_cmd.priv   = (sec == C_QM);
                              if (32'(cnt_new) > 32'(MAX_RESULTS)) begin
                                 push_cmd.run_cnt = RUN_CNT_W'(MAX_RESULTS);
                              end else begin
                                 push_cmd.run_cnt = RUN_CNT_W'(cnt_new);
                              end
                              busy_in    = 1'b1;
                              mode_in    = MODE_NORMAL;
                              esc_cnt_in = '0;
                           end else if (32'(cnt_new) >= 32'(ESCAPE_DEPTH)) begin
                              mode_in    = MODE_NORMAL;
                              esc_cnt_in = '0;
                           end else if (b < 8'h20 || b > 8'h3f) begin
                              mode_in    = MODE_NORMAL;
                              esc_cnt_in = '0;
                           end else if (esc_cnt_ff == EW'(1)) begin
                              if (b != C_QM) begin
                                 sf_bad_in = 1'b1;
                              end
                           end else if (!sf_found_ff && !sf_bad_ff) begin
                              if (b >= 8'h30 && b <= 8'h39) begin
                                 sp_in        = (sp_wide > 18'(SYNC_SAT)) ? SYNC_SAT
                                                                          : sp_wide[13:0];
                                 sf_digits_in = 1'b1;
                              end else if (b == 8'h3b) begin
                                 if (sf_digits_ff && sp_ff == SYNC_MODE) begin
                                    sf_found_in = 1'b1;
                                 end else begin
                                    sp_in        = '0;
                                    sf_digits_in = 1'b0;
                                 end
                              end else begin
                                 sf_bad_in = 1'b1;
                              end
                           end
                        end
                     end
                     8'h63: begin
                        emit           = 1'b1;
                        push_cmd.kind  = KIND_SIMPLE;
                        push_cmd.value = 31'(lead);
                        hold_in        = 1'b0;
                        mode_in        = MODE_NORMAL;
                        esc_cnt_in     = '0;
                     end
                     8'h67, 8'h3d, 8'h3e, 8'h37, 8'h38,
                     8'h44, 8'h45, 8'h48, 8'h4d: begin
                        emit           = 1'b1;
                        push_cmd.kind  = KIND_SIMPLE;
                        push_cmd.value = 31'(lead);
                        mode_in        = MODE_NORMAL;
                        esc_cnt_in     = '0;
                     end
                     8'h28, 8'h29: begin
                        if (32'(cnt_new) >= 32'd2) begin
                           emit           = 1'b1;
                           push_cmd.kind  = KIND_DESIGN;
                           push_cmd.value = 31'(lead);
                           push_cmd.aux   = sec;
                           mode_in        = MODE_NORMAL;
                           esc_cnt_in     = '0;
                        end
                     end
                     default: begin
                        mode_in    = MODE_NORMAL;
                        esc_cnt_in = '0;
                     end
                  endcase
               end
            end
            default: begin
               if (b == C_BEL) begin
                  emit          = 1'b1;
                  push_cmd.kind = KIND_STR_END;
                  push_cmd.aux  = str_type_ff;
                  mode_in       = MODE_NORMAL;
                  esc_cnt_in    = '0;
               end else if (b == C_ESC) begin
                  str_pend_in = 1'b1;
                  mode_in     = MODE_ESCAPE;
                  esc_cnt_in  = '0;
               end else if (str_cnt_ff < max_string_bytes) begin
                  emit           = 1'b1;
                  push_cmd.kind  = KIND_STR_BYTE;
                  push_cmd.value = 31'(b);
                  push_cmd.aux   = str_type_ff;
                  str_cnt_in     = str_cnt_ff + 1'b1;
               end
            end
         endcase

         if (do_normal) begin
            case (b)
               C_ESC: begin
                  mode_in    = MODE_ESCAPE;
                  esc_cnt_in = '0;
               end
               8'h0a, 8'h0d, 8'h08, 8'h09, 8'h0b, 8'h0c, 8'h07, 8'h0e, 8'h0f: begin
                  emit          = 1'b1;
                  push_cmd.kind = KIND_CONTROL;
                  case (b)
                     8'h0a:   push_cmd.value = 31'd0;
                     8'h0d:   push_cmd.value = 31'd1;
                     8'h08:   push_cmd.value = 31'd2;
                     8'h09:   push_cmd.value = 31'd3;
                     8'h0b:   push_cmd.value = 31'd4;
                     8'h0c:   push_cmd.value = 31'd5;
                     8'h07:   push_cmd.value = 31'd6;
                     8'h0e:   push_cmd.value = 31'd7;
                     default: push_cmd.value = 31'd8;
                  endcase
               end
               default: begin
                  if (!b[7]) begin
                     emit           = 1'b1;
                     push_cmd.kind  = KIND_PRINT;
                     push_cmd.value = 31'(b);
                  end else begin
                     u_cnt_in = 3'd1;
                     mode_in  = MODE_UTF8;
                     if (b[7:5] == 3'b110) begin
                        u_exp_in = 3'd2;
                        acc_in   = 31'(b[4:0]);
                     end else if (b[7:4] == 4'b1110) begin
                        u_exp_in = 3'd3;
                        acc_in   = 31'(b[3:0]);
                     end else if (b[7:3] == 5'b11110) begin
                        u_exp_in = 3'd4;
                        acc_in   = 31'(b[2:0]);
                     end else if (b[7:2] == 6'b111110) begin
                        u_exp_in = 3'd5;
                        acc_in   = 31'(b[1:0]);
                     end else if (b[7:1] == 7'b1111110) begin
                        u_exp_in = 3'd6;
                        acc_in   = 31'(b[0]);
                     end else begin
                        u_exp_in = 3'd0;
                        acc_in   = '0;
                     end
                  end
               end
            endcase
         end
      end

      push_cmd.hold = hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         u_cnt_ff     <= '0;
         u_exp_ff     <= '0;
         acc_ff       <= '0;
         esc_cnt_ff   <= '0;
         lead_ff      <= '0;
         second_ff    <= '0;
         str_type_ff  <= '0;
         str_cnt_ff   <= '0;
         str_pend_ff  <= 1'b0;
         hold_ff      <= 1'b0;
         sp_ff        <= '0;
         sf_digits_ff <= 1'b0;
         sf_found_ff  <= 1'b0;
         sf_bad_ff    <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         u_cnt_ff     <= u_cnt_in;
         u_exp_ff     <= u_exp_in;
         acc_ff       <= acc_in;
         esc_cnt_ff   <= esc_cnt_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
         str_type_ff  <= str_type_in;
         str_cnt_ff   <= str_cnt_in;
         str_pend_ff  <= str_pend_in;
         hold_ff      <= hold_in;
         sp_ff        <= sp_in;
         sf_digits_ff <= sf_digits_in;
         sf_found_ff  <= sf_found_in;
         sf_bad_ff    <= sf_bad_in;
         busy_ff      <= busy_in;
      end
   end

endmodule
`default_nettype wire

>>> design/teb_back.sv
`default_nettype none
module teb_back #(
   parameter int ESCAPE_DEPTH = teb_pkg::ESCAPE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  teb_pkg::cmd_type                       head_cmd,
   input  wire logic                              q_empty,
   output logic                                   pop,
   output logic                                   run_done,
   input  wire logic                              esc_we,
   input  wire logic [$clog2(ESCAPE_DEPTH)-1:0]   esc_waddr,
   input  wire logic [7:0]                        esc_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [2:0]                             rsp_kind,
   output logic [30:0]                            rsp_value,
   output logic [7:0]                             rsp_aux_byte,
   output logic                                   rsp_csi_private,
   output logic                                   rsp_hold,
   output logic                                   rsp_last
);
   import teb_pkg::*;

   localparam int AW = $clog2(ESCAPE_DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        idx_ff;
   logic [AW-1:0]        rd_addr;
   logic [RUN_CNT_W-1:0] cnt_ff;
   logic                 priv_ff;
   logic                 hold_ff;
   logic [7:0]           mem [ESCAPE_DEPTH];
   logic [7:0]           rdata_ff;
   logic                 out_free;
   logic                 run_last;

   logic                 valid_ff;
   logic [2:0]           kind_ff;
   logic [30:0]          value_ff;
   logic [7:0]           aux_ff;
   logic                 priv_out_ff;
   logic                 hold_out_ff;
   logic                 last_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_value       = value_ff;
   assign rsp_aux_byte    = aux_ff;
   assign rsp_csi_private = priv_out_ff;
   assign rsp_hold        = hold_out_ff;
   assign rsp_last        = last_ff;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign pop      = (state_ff == ST_IDLE) & ~q_empty & out_free;
   assign run_last = (RUN_CNT_W'(idx_ff) + RUN_CNT_W'(1)) == cnt_ff;
   assign run_done = (state_ff == ST_RUN) & out_free & run_last;

   // look one entry ahead so the stored byte is ready when the output frees
   always_comb begin
      if (state_ff == ST_RUN && out_free) begin
         rd_addr = idx_ff + 1'b1;
      end else if (state_ff == ST_RUN) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (esc_we) begin
         mem[esc_waddr] <= esc_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head_cmd.is_run) begin
                     state_ff <= ST_RUN;
                     idx_ff   <= '0;
                     cnt_ff   <= head_cmd.run_cnt;
                     priv_ff  <= head_cmd.priv;
                     hold_ff  <= head_cmd.hold;
                  end else begin
                     valid_ff    <= 1'b1;
                     kind_ff     <= head_cmd.kind;
                     value_ff    <= head_cmd.value;
                     aux_ff      <= head_cmd.aux;
                     priv_out_ff <= head_cmd.priv;
                     hold_out_ff <= head_cmd.hold;
                     last_ff     <= 1'b1;
                  end
               end
            end
            ST_RUN: begin
               if (out_free) begin
                  valid_ff    <= 1'b1;
                  kind_ff     <= KIND_CSI;
                  value_ff    <= 31'(rdata_ff);
                  aux_ff      <= '0;
                  priv_out_ff <= priv_ff;
                  hold_out_ff <= hold_ff;
                  last_ff     <= run_last;
                  idx_ff      <= idx_ff + 1'b1;
                  if (run_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> design/terminal_escape_byte_parser.sv
// Terminal output byte parser.
// Request channel: one raw byte per request on req_data_byte, taken when
// req_valid is high and req_stall low. Result channel: rsp_* fields, taken
// when rsp_valid is high and rsp_stall low; rsp_last marks the final result
// of one request's run, and a request may give no result at all.
// A request is classified as it is taken and its work goes into a two-entry
// job queue. Plain bytes, controls, escapes and string bytes go one per
// cycle while neither side stalls. A finished CSI sequence of N bytes (at
// most 32) is read back from the escape store one byte a cycle while the
// result side does not stall, occupying the result port for its N bytes,
// and req_stall stays high until its last byte reaches the output register.
// A stall on the result side holds the output register; the queue fills and
// then req_stall rises. Reset (synchronous) returns the parser to normal
// mode, clears the hold flag and the queue, and sets max_string_bytes to
// 65536. The escape store needs no clearing.
// The register max_string_bytes lies at address 0 of the APB-style port.
`default_nettype none
module terminal_escape_byte_parser #(
   parameter int ESCAPE_DEPTH = teb_pkg::ESCAPE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_data_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [30:0]       rsp_value,
   output logic [7:0]        rsp_aux_byte,
   output logic              rsp_csi_private,
   output logic              rsp_hold,
   output logic              rsp_last,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [1:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import teb_pkg::*;

   localparam int AW = $clog2(ESCAPE_DEPTH);
   localparam logic [1:0] ADDR_MAX_STRING = 2'd0;

   logic [MAX_STR_W-1:0] max_str_ff;
   cmd_type              push_cmd;
   cmd_type              head_cmd;
   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   logic                 run_done;
   logic                 esc_we;
   logic [AW-1:0]        esc_waddr;
   logic [7:0]           esc_wdata;

   assign pready = 1'b1;
   assign prdata = 32'(max_str_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_str_ff <= MAX_STR_RESET;
      end else if (psel && penable && pwrite && paddr == ADDR_MAX_STRING) begin
         max_str_ff <= pwdata[MAX_STR_W-1:0];
      end
   end

   teb_front #(.ESCAPE_DEPTH(ESCAPE_DEPTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_stall        (req_stall),
      .max_string_bytes (max_str_ff),
      .push             (push),
      .push_cmd         (push_cmd),
      .q_full           (q_full),
      .run_done         (run_done),
      .esc_we           (esc_we),
      .esc_waddr        (esc_waddr),
      .esc_wdata        (esc_wdata)
   );

   teb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   teb_back #(.ESCAPE_DEPTH(ESCAPE_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_empty         (q_empty),
      .pop             (pop),
      .run_done        (run_done),
      .esc_we          (esc_we),
      .esc_waddr       (esc_waddr),
      .esc_wdata       (esc_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_aux_byte    (rsp_aux_byte),
      .rsp_csi_private (rsp_csi_private),
      .rsp_hold        (rsp_hold),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

>>> design/teb_checker.sv
`default_nettype none
module teb_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire logic [2:0]   rsp_kind,
   input  wire logic [30:0]  rsp_value,
   input  wire logic         rsp_csi_private,
   input  wire logic         rsp_hold,
   input  wire logic         rsp_last
);
   import teb_pkg::*;

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_kind))
      else $error("stalled result changed");

   // only a CSI run gives more than one result per request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CSI |-> rsp_last)
      else $error("non-CSI result not last");

   // the private flag belongs to CSI bytes only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CSI |-> !rsp_csi_private)
      else $error("private flag outside CSI");

   // within one CSI run the hold flag does not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_CSI && !rsp_last ##1 rsp_valid
      |-> rsp_kind == KIND_CSI && rsp_hold == $past(rsp_hold))
      else $error("CSI run broken");

endmodule

bind terminal_escape_byte_parser teb_checker u_teb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_value       (rsp_value),
   .rsp_csi_private (rsp_csi_private),
   .rsp_hold        (rsp_hold),
   .rsp_last        (rsp_last)
);
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
   import teb_pkg::*;

   localparam int ESC_DEPTH = 32;
   localparam int RESULT_CAP = 32;
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_UTF8   = 2'd1;
   localparam logic [1:0] MODE_ESCAPE = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;
   localparam logic [2:0] SYNC_DIGITS = 3'd1;
   localparam logic [2:0] SYNC_FOUND  = 3'd2;
   localparam logic [2:0] SYNC_BAD    = 3'd4;
   localparam logic [1:0] ADDR_MAX_STRING = 2'd0;
   localparam logic [7:0] ESC = 8'h1b;
   localparam logic [7:0] BEL = 8'h07;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [2:0]  kind;
      logic [30:0] value;
      logic [7:0]  aux;
      logic        priv;
      logic        hold;
      logic        last;
   } term_event_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [7:0] req_data_byte;
   logic rsp_valid, rsp_stall;
   logic [2:0] rsp_kind;
   logic [30:0] rsp_value;
   logic [7:0] rsp_aux_byte;
   logic rsp_csi_private, rsp_hold, rsp_last;
   logic psel, penable, pwrite, pready;
   logic [1:0] paddr;
   logic [31:0] pwdata, prdata;

   terminal_escape_byte_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_value(rsp_value), .rsp_aux_byte(rsp_aux_byte),
      .rsp_csi_private(rsp_csi_private), .rsp_hold(rsp_hold), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // parser shadow state
   logic [20:0] max_string;
   logic [1:0]  mode;
   logic [2:0]  u_count, u_expected;
   logic [30:0] code_acc;
   logic [7:0]  esc_store [ESC_DEPTH];
   int          esc_count;
   logic [7:0]  str_type;
   logic [20:0] str_count;
   logic        str_pending, hold_flag;
   logic [13:0] sync_param;
   logic [2:0]  sync_flags;

   term_event_type run_buf [$];
   term_event_type expected_events [$];
   logic [7:0]  byte_queue [$];

   int  errors = 0, cycles = 0, bytes_sent = 0, events_seen = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  send_pause = 0;
   bit  hold_go = 0;
   int  hold_cnt = 0;
   logic long_hold;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void emit(logic [2:0] k, logic [30:0] v, logic [7:0] a, logic p);
      term_event_type e;
      if (run_buf.size() >= RESULT_CAP) return;
      e = '{kind: k, value: v, aux: a, priv: p, hold: 1'b0, last: 1'b0};
      run_buf.push_back(e);
   endfunction

   function automatic void normal_byte(logic [7:0] b);
      case (b)
         ESC: begin mode = MODE_ESCAPE; esc_count = 0; return; end
         8'h0a: begin emit(KIND_CONTROL, 31'd0, 8'd0, 1'b0); return; end
         8'h0d: begin emit(KIND_CONTROL, 31'd1, 8'd0, 1'b0); return; end
         8'h08: begin emit(KIND_CONTROL, 31'd2, 8'd0, 1'b0); return; end
         8'h09: begin emit(KIND_CONTROL, 31'd3, 8'd0, 1'b0); return; end
         8'h0b: begin emit(KIND_CONTROL, 31'd4, 8'd0, 1'b0); return; end
         8'h0c: begin emit(KIND_CONTROL, 31'd5, 8'd0, 1'b0); return; end
         8'h07: begin emit(KIND_CONTROL, 31'd6, 8'd0, 1'b0); return; end
         8'h0e: begin emit(KIND_CONTROL, 31'd7, 8'd0, 1'b0); return; end
         8'h0f: begin emit(KIND_CONTROL, 31'd8, 8'd0, 1'b0); return; end
         default: ;
      endcase
      if (b < 8'h80) begin
         emit(KIND_PRINT, {23'd0, b}, 8'd0, 1'b0);
         return;
      end
      u_count = 3'd1;
      if ((b & 8'hE0) == 8'hC0) begin
         u_expected = 3'd2; code_acc = 31'(b & 8'h1F);
      end else if ((b & 8'hF0) == 8'hE0) begin
         u_expected = 3'd3; code_acc = 31'(b & 8'h0F);
      end else if ((b & 8'hF8) == 8'hF0) begin
         u_expected = 3'd4; code_acc = 31'(b & 8'h07);
      end else if ((b & 8'hFC) == 8'hF8) begin
         u_expected = 3'd5; code_acc = 31'(b & 8'h03);
      end else if ((b & 8'hFE) == 8'hFC) begin
         u_expected = 3'd6; code_acc = 31'(b & 8'h01);
      end else begin
         u_expected = 3'd0; code_acc = '0;
      end
      mode = MODE_UTF8;
   endfunction

   function automatic void track_sync(logic [7:0] b, int idx);
      int nv;
      if (idx == 1) begin
         if (b != "?") sync_flags |= SYNC_BAD;
         return;
      end
      if ((sync_flags & (SYNC_FOUND | SYNC_BAD)) != 0) return;
      if (b >= "0" && b <= "9") begin
         nv = int'(sync_param) * 10 + int'(b - 8'h30);
         sync_param = (nv > 16383) ? 14'd16383 : nv[13:0];
         sync_flags |= SYNC_DIGITS;
      end else if (b == ";") begin
         if ((sync_flags & SYNC_DIGITS) != 0 && sync_param == 14'd2026)
            sync_flags |= SYNC_FOUND;
         else begin
            sync_param = '0;
            sync_flags &= ~SYNC_DIGITS;
         end
      end else
         sync_flags |= SYNC_BAD;
   endfunction

   function automatic void finish_csi(logic [7:0] b);
      logic p, hit;
      p = (esc_store[1] == "?");
      hit = 0;
      if (esc_count >= 3 && (b == "h" || b == "l")) begin
         if ((sync_flags & SYNC_FOUND) != 0) hit = 1;
         else if ((sync_flags & SYNC_BAD) == 0 && (sync_flags & SYNC_DIGITS) != 0 &&
                  sync_param == 14'd2026) hit = 1;
      end
      for (int k = 0; k < esc_count && k < ESC_DEPTH; k++)
         emit(KIND_CSI, {23'd0, esc_store[k]}, 8'd0, p);
      if (hit) hold_flag = (b == "h");
      mode = MODE_NORMAL; esc_count = 0;
   endfunction

   function automatic void escape_byte(logic [7:0] b);
      int idx;
      logic [7:0] lead;
      if (b == ESC) begin esc_count = 0; return; end
      if (esc_count >= ESC_DEPTH) begin mode = MODE_NORMAL; esc_count = 0; return; end
      idx = esc_count;
      esc_store[idx] = b;
      esc_count = idx + 1;
      if (idx == 0) begin sync_param = '0; sync_flags = '0; end
      lead = esc_store[0];
      case (lead)
         "N", "O", "\\": begin
            if (str_pending) begin
               emit(KIND_STR_END, 31'd0, str_type, 1'b0);
               str_pending = 0;
            end
            mode = MODE_NORMAL; esc_count = 0;
         end
         "P", "]", "X", "^", "_": begin
            str_type = lead; str_count = '0; str_pending = 0;
            mode = MODE_STRING; esc_count = 0;
         end
         "[": begin
            if (esc_count > 1) begin
               if (b >= 8'h40 && b <= 8'h7e) finish_csi(b);
               else if (esc_count >= ESC_DEPTH) begin mode = MODE_NORMAL; esc_count = 0; end
               else if (b < 8'h20 || b > 8'h3f) begin mode = MODE_NORMAL; esc_count = 0; end
               else track_sync(b, idx);
            end
         end
         "c": begin
            emit(KIND_SIMPLE, {23'd0, lead}, 8'd0, 1'b0);
            hold_flag = 0;
            mode = MODE_NORMAL; esc_count = 0;
         end
         "g", "=", ">", "7", "8", "D", "E", "H", "M": begin
            emit(KIND_SIMPLE, {23'd0, lead}, 8'd0, 1'b0);
            mode = MODE_NORMAL; esc_count = 0;
         end
         "(", ")": begin
            if (esc_count >= 2) begin
               emit(KIND_DESIGN, {23'd0, lead}, esc_store[1], 1'b0);
               mode = MODE_NORMAL; esc_count = 0;
            end
         end
         default: begin mode = MODE_NORMAL; esc_count = 0; end
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      run_buf.delete();
      case (mode)
         MODE_NORMAL: normal_byte(b);
         MODE_UTF8: begin
            if (b[7:6] != 2'b10) begin
               u_count = '0; u_expected = '0; code_acc = '0; mode = MODE_NORMAL;
               normal_byte(b);
            end else begin
               u_count++;
               code_acc = {code_acc[24:0], b[5:0]};
               if (u_count == u_expected) begin
                  emit(KIND_PRINT, code_acc, 8'd0, 1'b0);
                  u_count = '0; u_expected = '0; code_acc = '0; mode = MODE_NORMAL;
               end else if (u_count >= 3'd6 || u_count > u_expected) begin
                  u_count = '0; u_expected = '0; code_acc = '0; mode = MODE_NORMAL;
               end
            end
         end
         MODE_ESCAPE: escape_byte(b);
         default: begin
            if (b == BEL) begin
               emit(KIND_STR_END, 31'd0, str_type, 1'b0);
               mode = MODE_NORMAL; esc_count = 0;
            end else if (b == ESC) begin
               str_pending = 1; mode = MODE_ESCAPE; esc_count = 0;
            end else if (str_count < max_string) begin
               emit(KIND_STR_BYTE, {23'd0, b}, str_type, 1'b0);
               str_count++;
            end
         end
      endcase
      foreach (run_buf[k]) begin
         run_buf[k].hold = hold_flag;
         run_buf[k].last = (k == run_buf.size() - 1);
         expected_events.push_back(run_buf[k]);
      end
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_data_byte <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte);
            bytes_sent <= bytes_sent + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (byte_queue.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               req_data_byte <= byte_queue.pop_front();
            end else
               req_valid <= 0;
         end
      end
   end

   // long receiver hold-off, counted once started
   assign long_hold = hold_go && (hold_cnt < LONG_HOLD_CYCLES);

   always @(posedge clock) begin
      if (long_hold)
         hold_cnt <= hold_cnt + 1;
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      term_event_type got, exp_ev;
      if (reset)
         rsp_stall <= 0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            events_seen <= events_seen + 1;
            got = '{rsp_kind, rsp_value, rsp_aux_byte, rsp_csi_private, rsp_hold, rsp_last};
            if (expected_events.size() == 0) begin
               $error("unexpected result kind=%0d value=%0h", got.kind, got.value);
               errors++;
            end else begin
               exp_ev = expected_events.pop_front();
               if (got.kind != exp_ev.kind) begin
                  $error("kind exp %0d got %0d", exp_ev.kind, got.kind); errors++; end
               if (got.value != exp_ev.value) begin
                  $error("value exp %0h got %0h", exp_ev.value, got.value); errors++; end
               if (got.aux != exp_ev.aux) begin
                  $error("aux_byte exp %0h got %0h", exp_ev.aux, got.aux); errors++; end
               if (got.priv != exp_ev.priv) begin
                  $error("csi_private exp %0b got %0b", exp_ev.priv, got.priv); errors++; end
               if (got.hold != exp_ev.hold) begin
                  $error("hold exp %0b got %0b", exp_ev.hold, got.hold); errors++; end
               if (got.last != exp_ev.last) begin
                  $error("last exp %0b got %0b", exp_ev.last, got.last); errors++; end
            end
         end
         if (long_hold)
            rsp_stall <= 1;
         else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_max_string(logic [20:0] val);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_MAX_STRING; pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      max_string = val;
      @(posedge clock);
      if (prdata != 32'(val)) begin
         $error("max_string_bytes exp %0h got %0h", val, prdata);
         errors++;
      end
   endtask

   task automatic drain;
      while (byte_queue.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_str(string s);
      foreach (s[i]) byte_queue.push_back(s[i]);
   endtask

   task automatic push_csi;
      int n, v;
      byte_queue.push_back(ESC);
      byte_queue.push_back("[");
      if ($urandom_range(1)) byte_queue.push_back("?");
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         v = ($urandom_range(3) == 0) ? 2026 : int'($urandom_range(20000));
         push_str($sformatf("%0d", v));
         if (i != n - 1) byte_queue.push_back(";");
      end
      case ($urandom_range(7))
         0: byte_queue.push_back("h");
         1: byte_queue.push_back("l");
         2: byte_queue.push_back(8'($urandom_range(8'h20, 8'h3f)));
         3: byte_queue.push_back(8'($urandom_range(8'h00, 8'h1f)));
         4: byte_queue.push_back(8'($urandom_range(8'h80, 8'hff)));
         default: byte_queue.push_back(8'($urandom_range(8'h40, 8'h7e)));
      endcase
   endtask

   task automatic push_random(int count);
      logic [7:0] simple_set [10] = '{"c", "g", "=", ">", "7", "8", "D", "E", "H", "M"};
      logic [7:0] str_set [5] = '{"P", "]", "X", "^", "_"};
      int n;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0, 1: push_csi();
            2: begin
               byte_queue.push_back(ESC);
               byte_queue.push_back(simple_set[$urandom_range(9)]);
            end
            3: begin
               byte_queue.push_back(ESC);
               byte_queue.push_back($urandom_range(1) ? "(" : ")");
               byte_queue.push_back(8'($urandom_range(255)));
            end
            4: begin
               byte_queue.push_back(ESC);
               byte_queue.push_back(str_set[$urandom_range(4)]);
               n = $urandom_range(6);
               repeat (n) byte_queue.push_back(8'($urandom_range(8'h20, 8'hff)));
               case ($urandom_range(3))
                  0: byte_queue.push_back(BEL);
                  1: begin byte_queue.push_back(ESC); byte_queue.push_back("\\"); end
                  2: begin byte_queue.push_back(ESC); byte_queue.push_back("N"); end
                  default: begin byte_queue.push_back(ESC); byte_queue.push_back("O"); end
               endcase
            end
            5: begin
               n = $urandom_range(2, 6);
               byte_queue.push_back(8'((8'hff << (8 - n)) |
                                       $urandom_range((1 << (7 - n)) - 1)));
               repeat ($urandom_range(n - 1, n))
                  byte_queue.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
            6: byte_queue.push_back(8'($urandom_range(8'h20, 8'h7e)));
            7: byte_queue.push_back(8'($urandom_range(8'h00, 8'h1f)));
            default: byte_queue.push_back(8'($urandom_range(255)));
         endcase
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_data_byte = 0; rsp_stall = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      max_string = MAX_STR_RESET;
      mode = MODE_NORMAL; u_count = 0; u_expected = 0; code_acc = 0; esc_count = 0;
      str_type = 0; str_count = 0; str_pending = 0; hold_flag = 0;
      sync_param = 0; sync_flags = 0;
      send_idle_pct = 32; recv_idle_pct = 74;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: controls, printables, utf-8, sync on/off, RIS, strings
      push_str("A~");
      byte_queue.push_back(8'h00); byte_queue.push_back(8'h7f);
      byte_queue.push_back(8'h0a); byte_queue.push_back(8'h0f);
      byte_queue.push_back(8'hc3); byte_queue.push_back(8'ha9);
      byte_queue.push_back(8'hfd); repeat (5) byte_queue.push_back(8'hbf);
      byte_queue.push_back(8'he2); byte_queue.push_back("x");
      byte_queue.push_back(8'hff); byte_queue.push_back(8'h80);
      byte_queue.push_back(ESC); push_str("[?2026h");
      byte_queue.push_back(ESC); push_str("[?1;2026;5l");
      byte_queue.push_back(ESC); push_str("[?99999h");
      byte_queue.push_back(ESC); push_str("[?2026h");
      byte_queue.push_back(ESC); byte_queue.push_back("c");
      byte_queue.push_back(ESC); push_str("(B");
      byte_queue.push_back(ESC); push_str("]0;t");
      byte_queue.push_back(ESC); byte_queue.push_back(ESC); push_str("\\");
      byte_queue.push_back(ESC); push_str("Pab"); byte_queue.push_back(BEL);
      byte_queue.push_back(ESC); byte_queue.push_back("Z");
      byte_queue.push_back(ESC); byte_queue.push_back("[");
      repeat (31) byte_queue.push_back("1");
      drain();

      // CSI of 31 stored bytes under a long receiver hold-off
      write_max_string(21'd3);
      byte_queue.push_back(ESC); byte_queue.push_back("[");
      repeat (29) byte_queue.push_back("2");
      byte_queue.push_back("m");
      byte_queue.push_back(ESC); push_str("Xabcdefg"); byte_queue.push_back(BEL);
      hold_go = 1;
      push_random(6);
      drain();

      write_max_string(21'd0);
      byte_queue.push_back(ESC); push_str("^zz"); byte_queue.push_back(BEL);
      push_random(10);
      drain();

      write_max_string(21'h1fffff);
      send_idle_pct = 74; recv_idle_pct = 32;
      push_random(10);
      // sender holds back until everything has come out
      while (byte_queue.size() > 20) @(posedge clock);
      send_pause = 1;
      while (req_valid || expected_events.size() != 0) @(posedge clock);
      send_pause = 0;
      drain();

      write_max_string(21'd2);
      send_idle_pct = 0; recv_idle_pct = 0;
      push_random(10);
      drain();

      $display("Sent %0d bytes, checked %0d results across string limits 0,2,3,max.",
               bytes_sent, events_seen);
      $display("Covered controls, UTF-8, CSI/sync hold, charsets, strings, stalls.");
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
design/teb_pkg.sv
design/teb_queue.sv
design/teb_front.sv
design/teb_back.sv
design/terminal_escape_byte_parser.sv
design/teb_checker.sv
test/testbench.sv
